// ===== rtl/core/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared constants, the orientation sign type and the edge/ray meet function.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int RAY_FAR_RESET   = 9999;

    // Sign of an orientation value; neg is only set when zero is clear.
    typedef struct packed {
        logic zero;
        logic neg;
    } sgn_t;

    // Box check bits of one edge against the ray.
    typedef enum logic [1:0] {
        BOX_QUERY  = 2'd0,  // query point inside edge box
        BOX_FAR    = 2'd1,  // far end of ray inside edge box
        BOX_EDGE_A = 2'd2,  // edge start on the ray
        BOX_EDGE_B = 2'd3   // edge end on the ray
    } box_idx_t;

    function automatic logic edge_meets(
        input sgn_t       o1,
        input sgn_t       o2,
        input sgn_t       o3,
        input sgn_t       o4,
        input logic [3:0] box
    );
        logic proper;
        logic touch;
        begin
            proper = (o1 != o2) && (o3 != o4);
            touch  = (o1.zero && box[BOX_QUERY])
                  || (o2.zero && box[BOX_FAR])
                  || (o3.zero && box[BOX_EDGE_A])
                  || (o4.zero && box[BOX_EDGE_B]);
            edge_meets = proper || touch;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pip_if.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon channels
// Vertex request, result request and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_item_if
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          first_vertex;
    logic                          last_vertex;

    modport source (
        output valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        output ready
    );
endinterface

interface pip_result_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink (input valid, inside_res, output ready);
endinterface

interface pip_cfg_if
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ray_far_x;

    modport source (output valid, ray_far_x, input ready);
    modport sink (input valid, ray_far_x, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/point_in_polygon_ray_cast.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon ray cast
// Streams polygon vertices, tests each edge and the closing edge against a
// horizontal ray from the query point and reports the crossing parity.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | handshake
//  item    | in  | query_x/y, vertex_x/y, first_vertex, last_vertex | valid/ready
//  result  | out | inside_res (one per last vertex)                 | valid/ready
//  cfg     | in  | ray_far_x                                        | valid/ready
//
//  One vertex per cycle while input ready is high; the result is valid
//  after the input register, product register and result register. The
//  edge products are the deepest path. rst_n clears valid flags, parity,
//  stored vertices and sets ray_far_x to 9999. A stalled result holds only
//  a last vertex behind it; other vertices keep flowing and input ready
//  drops only then.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_ray_cast
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire           clk,
    input  wire           rst_n,
    pip_item_if.sink      item,
    pip_result_if.source  result,
    pip_cfg_if.sink       cfg
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam logic signed [W-1:0] FAR_RESET = W'(RAY_FAR_RESET);

    // ---------------- configuration ----------------
    logic signed [W-1:0] ray_far_x_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_far_x_reg <= FAR_RESET;
        end
        else if (cfg.valid)
        begin
            ray_far_x_reg <= cfg.ray_far_x;
        end
    end

    // ---------------- flow control ----------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_stall, s2_hold, s2_free, s1_hold, s2_done, in_accept, s1_move;
    logic s2_last_reg, s2_first_reg;

    assign out_stall = out_valid_reg && !result.ready;
    assign s2_hold   = s2_valid_reg && s2_last_reg && out_stall;
    assign s2_free   = !s2_valid_reg || !s2_hold;
    assign s1_hold   = s1_valid_reg && !s2_free;
    assign s1_move   = s1_valid_reg && s2_free;
    assign s2_done   = s2_valid_reg && !s2_hold;
    assign item.ready = !s1_hold;
    assign in_accept = item.valid && !s1_hold;

    always_comb
    begin
        s1_valid_next  = in_accept || s1_hold;
        s2_valid_next  = s1_move || s2_hold;
        out_valid_next = (s2_done && s2_last_reg) || out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- vertex tracking at the input ----------------
    logic signed [W-1:0] prev_x_reg, prev_y_reg, start_x_reg, start_y_reg;
    logic signed [W-1:0] start_x_next, start_y_next;

    always_comb
    begin
        start_x_next = item.first_vertex ? item.vertex_x : start_x_reg;
        start_y_next = item.first_vertex ? item.vertex_y : start_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
        end
        else if (in_accept)
        begin
            prev_x_reg  <= item.vertex_x;
            prev_y_reg  <= item.vertex_y;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic signed [W-1:0] s1_qx_reg, s1_qy_reg, s1_vx_reg, s1_vy_reg;
    logic signed [W-1:0] s1_px_reg, s1_py_reg, s1_sx_reg, s1_sy_reg;
    logic                s1_first_reg, s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_qx_reg    <= item.query_x;
            s1_qy_reg    <= item.query_y;
            s1_vx_reg    <= item.vertex_x;
            s1_vy_reg    <= item.vertex_y;
            s1_px_reg    <= prev_x_reg;
            s1_py_reg    <= prev_y_reg;
            s1_sx_reg    <= start_x_next;
            s1_sy_reg    <= start_y_next;
            s1_first_reg <= item.first_vertex;
            s1_last_reg  <= item.last_vertex;
        end
    end

    // Edge 0: previous vertex to current; edge 1: current back to start.
    logic signed [W-1:0]  ax [2];
    logic signed [W-1:0]  ay [2];
    logic signed [W-1:0]  bx [2];
    logic signed [W-1:0]  by [2];
    logic signed [PW-1:0] prod_p_next [2];
    logic signed [PW-1:0] prod_r_next [2];
    logic signed [PW-1:0] prod_s_next [2];
    sgn_t                 o3_next [2];
    sgn_t                 o4_next [2];
    logic [3:0]           box_next [2];

    assign ax[0] = s1_px_reg;
    assign ay[0] = s1_py_reg;
    assign bx[0] = s1_vx_reg;
    assign by[0] = s1_vy_reg;
    assign ax[1] = s1_vx_reg;
    assign ay[1] = s1_vy_reg;
    assign bx[1] = s1_sx_reg;
    assign by[1] = s1_sy_reg;

    always_comb
    begin
        logic signed [DW-1:0] d_ab_y, d_qb_x, d_fb_x, d_qb_y, d_ab_x;
        logic signed [W-1:0]  lx, hx, ly, hy, lrx, hrx;
        logic                 zx, nx, za, na, zb, nb;
        for (int e = 0; e < 2; e++)
        begin
            d_ab_y = DW'(by[e]) - DW'(ay[e]);
            d_qb_x = DW'(s1_qx_reg) - DW'(bx[e]);
            d_fb_x = DW'(ray_far_x_reg) - DW'(bx[e]);
            d_qb_y = DW'(s1_qy_reg) - DW'(by[e]);
            d_ab_x = DW'(bx[e]) - DW'(ax[e]);
            prod_p_next[e] = d_ab_y * d_qb_x;
            prod_r_next[e] = d_ab_y * d_fb_x;
            prod_s_next[e] = d_qb_y * d_ab_x;

            lx  = (ax[e] < bx[e]) ? ax[e] : bx[e];
            hx  = (ax[e] < bx[e]) ? bx[e] : ax[e];
            ly  = (ay[e] < by[e]) ? ay[e] : by[e];
            hy  = (ay[e] < by[e]) ? by[e] : ay[e];
            lrx = (s1_qx_reg < ray_far_x_reg) ? s1_qx_reg : ray_far_x_reg;
            hrx = (s1_qx_reg < ray_far_x_reg) ? ray_far_x_reg : s1_qx_reg;
            box_next[e][BOX_QUERY]  = (s1_qx_reg >= lx) && (s1_qx_reg <= hx)
                                   && (s1_qy_reg >= ly) && (s1_qy_reg <= hy);
            box_next[e][BOX_FAR]    = (ray_far_x_reg >= lx) && (ray_far_x_reg <= hx)
                                   && (s1_qy_reg >= ly) && (s1_qy_reg <= hy);
            box_next[e][BOX_EDGE_A] = (ax[e] >= lrx) && (ax[e] <= hrx)
                                   && (ay[e] == s1_qy_reg);
            box_next[e][BOX_EDGE_B] = (bx[e] >= lrx) && (bx[e] <= hrx)
                                   && (by[e] == s1_qy_reg);

            // Ray is horizontal: orientation of a point is -(y - qy)*(fx - qx).
            zx = (ray_far_x_reg == s1_qx_reg);
            nx = (ray_far_x_reg < s1_qx_reg);
            za = (ay[e] == s1_qy_reg);
            na = (ay[e] < s1_qy_reg);
            zb = (by[e] == s1_qy_reg);
            nb = (by[e] < s1_qy_reg);
            o3_next[e].zero = za || zx;
            o3_next[e].neg  = !(za || zx) && !(na ^ nx);
            o4_next[e].zero = zb || zx;
            o4_next[e].neg  = !(zb || zx) && !(nb ^ nx);
        end
    end

    // ---------------- stage 2: product register ----------------
    logic signed [PW-1:0] prod_p_reg [2];
    logic signed [PW-1:0] prod_r_reg [2];
    logic signed [PW-1:0] prod_s_reg [2];
    sgn_t                 o3_reg [2];
    sgn_t                 o4_reg [2];
    logic [3:0]           box_reg [2];

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int e = 0; e < 2; e++)
            begin
                prod_p_reg[e] <= prod_p_next[e];
                prod_r_reg[e] <= prod_r_next[e];
                prod_s_reg[e] <= prod_s_next[e];
                o3_reg[e]     <= o3_next[e];
                o4_reg[e]     <= o4_next[e];
                box_reg[e]    <= box_next[e];
            end
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    logic [1:0] meet;

    always_comb
    begin
        sgn_t o1, o2;
        for (int e = 0; e < 2; e++)
        begin
            o1.zero = (prod_p_reg[e] == prod_s_reg[e]);
            o1.neg  = (prod_p_reg[e] < prod_s_reg[e]);
            o2.zero = (prod_r_reg[e] == prod_s_reg[e]);
            o2.neg  = (prod_r_reg[e] < prod_s_reg[e]);
            meet[e] = edge_meets(o1, o2, o3_reg[e], o4_reg[e], box_reg[e]);
        end
    end

    // ---------------- parity and result ----------------
    logic parity_reg, parity_next;
    logic inside_reg;

    always_comb
    begin
        parity_next = s2_first_reg ? 1'b0 : (parity_reg ^ meet[0]);
        parity_next = parity_next ^ (s2_last_reg && meet[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= 1'b0;
        end
        else if (s2_done)
        begin
            parity_reg <= parity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_done && s2_last_reg)
        begin
            inside_reg <= parity_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.inside_res = inside_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pip_checker.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon port checker
// Watches the top level's channels and flags stall and ready slips.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_checker
(
    input wire clk,
    input wire rst_n,
    input wire item_ready,
    input wire res_valid,
    input wire res_ready,
    input wire res_inside,
    input wire cfg_ready
);

    // Hold a stalled result and its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_inside))
        else $error("stalled result dropped or changed");

    // Drop input ready only behind a stalled result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> res_valid && !res_ready)
        else $error("input ready low without a stalled result");

    // Accept configuration writes at any time.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind point_in_polygon_ray_cast pip_checker u_pip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_inside (result.inside_res),
    .cfg_ready  (cfg.ready)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon ray cast testbench
// Streams directed and random polygons through the block, changes the far
// end of the test ray between phases and checks every inside flag against
// a crossing-parity tracker kept alongside the block.
// ----------------------------------------------------------------------------

typedef logic signed [pip_pkg::COORD_WIDTH_DEF-1:0] coord_t;

class crossing_tracker;
    coord_t far_x;
    coord_t first_x;
    coord_t first_y;
    coord_t last_x;
    coord_t last_y;
    bit     parity;
    bit     inside_q[$];
    int     errors;

    function new();
        far_x   = coord_t'(pip_pkg::RAY_FAR_RESET);
        first_x = '0;
        first_y = '0;
        last_x  = '0;
        last_y  = '0;
        parity  = 1'b0;
        errors  = 0;
    endfunction

    function void set_far(coord_t v);
        far_x = v;
    endfunction

    function int pending();
        return inside_q.size();
    endfunction

    function int orient(longint ax, longint ay, longint bx, longint by,
                        longint cx, longint cy);
        longint r;
        r = (by - ay) * (cx - bx) - (cy - by) * (bx - ax);
        return (r > 0) ? 1 : ((r < 0) ? -1 : 0);
    endfunction

    function bit in_box(longint ax, longint ay, longint bx, longint by,
                        longint px, longint py);
        longint hx;
        longint lx;
        longint hy;
        longint ly;
        hx = (ax > bx) ? ax : bx;
        lx = (ax < bx) ? ax : bx;
        hy = (ay > by) ? ay : by;
        ly = (ay < by) ? ay : by;
        return (px <= hx) && (px >= lx) && (py <= hy) && (py >= ly);
    endfunction

    // Edge a-b against the ray from q to (f, qy).
    function bit edge_hits_ray(longint ax, longint ay, longint bx, longint by,
                               longint qx, longint qy, longint fx);
        int o1;
        int o2;
        int o3;
        int o4;
        o1 = orient(ax, ay, bx, by, qx, qy);
        o2 = orient(ax, ay, bx, by, fx, qy);
        o3 = orient(qx, qy, fx, qy, ax, ay);
        o4 = orient(qx, qy, fx, qy, bx, by);
        if (o1 != o2 && o3 != o4)
            return 1'b1;
        if (o1 == 0 && in_box(ax, ay, bx, by, qx, qy))
            return 1'b1;
        if (o2 == 0 && in_box(ax, ay, bx, by, fx, qy))
            return 1'b1;
        if (o3 == 0 && in_box(qx, qy, fx, qy, ax, ay))
            return 1'b1;
        if (o4 == 0 && in_box(qx, qy, fx, qy, bx, by))
            return 1'b1;
        return 1'b0;
    endfunction

    function void note_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy,
                              bit first, bit last);
        if (first)
        begin
            first_x = vx;
            first_y = vy;
            parity  = 1'b0;
        end
        else if (edge_hits_ray(last_x, last_y, vx, vy, qx, qy, far_x))
        begin
            parity = ~parity;
        end
        last_x = vx;
        last_y = vy;
        if (last)
        begin
            // closing edge back to the first vertex
            if (edge_hits_ray(vx, vy, first_x, first_y, qx, qy, far_x))
                parity = ~parity;
            inside_q.push_back(parity);
        end
    endfunction

    function void check_inside(bit got);
        bit exp;
        if (inside_q.size() == 0)
        begin
            $display("%0t: inside_res %0d with no request pending", $time, got);
            errors++;
        end
        else
        begin
            exp = inside_q.pop_front();
            if (exp !== got)
            begin
                $display("%0t: inside_res mismatch, expected %0d actual %0d",
                         $time, exp, got);
                errors++;
            end
        end
    endfunction
endclass

module tb;

    logic clk;
    logic rst_n;
    int   sent;

    pip_item_if #(.COORD_WIDTH(pip_pkg::COORD_WIDTH_DEF)) item_ch();
    pip_result_if                                         res_ch();
    pip_cfg_if #(.COORD_WIDTH(pip_pkg::COORD_WIDTH_DEF))  cfg_ch();

    crossing_tracker sb = new();

    point_in_polygon_ray_cast #(
        .COORD_WIDTH(pip_pkg::COORD_WIDTH_DEF)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom_range(0, 16)) - coord_t'(8);
            1: return coord_t'($urandom);
            default: return coord_t'($urandom_range(0, 600)) - coord_t'(300);
        endcase
    endfunction

    task automatic send_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy,
                               bit first, bit last);
        @(negedge clk);
        item_ch.valid        = 1'b1;
        item_ch.query_x      = qx;
        item_ch.query_y      = qy;
        item_ch.vertex_x     = vx;
        item_ch.vertex_y     = vy;
        item_ch.first_vertex = first;
        item_ch.last_vertex  = last;
        forever
        begin
            @(posedge clk);
            if (item_ch.ready)
                break;
        end
        sb.note_vertex(qx, qy, vx, vy, first, last);
        sent++;
    endtask

    task automatic idle_item(int n);
        if (n > 0)
        begin
            @(negedge clk);
            item_ch.valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Drain every request, then let in-flight vertices settle before writing.
    task automatic write_far(coord_t v);
        idle_item(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.ray_far_x = v;
        forever
        begin
            @(posedge clk);
            if (cfg_ch.ready)
                break;
        end
        sb.set_far(v);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic random_polygon();
        int     mode;
        int     nv;
        bit     calm;
        bit     noise;
        bit     fst;
        bit     lst;
        coord_t qx;
        coord_t qy;
        mode  = $urandom_range(0, 2);
        nv    = $urandom_range(1, 8);
        calm  = ($urandom_range(0, 4) == 0);
        noise = ($urandom_range(0, 9) == 0);
        qx    = rnd_coord(mode);
        qy    = rnd_coord(mode);
        for (int i = 0; i < nv; i++)
        begin
            if (noise)
            begin
                fst = ($urandom_range(0, 3) == 0);
                lst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1))
                begin
                    qx = rnd_coord(mode);
                    qy = rnd_coord(mode);
                end
            end
            else
            begin
                fst = (i == 0);
                lst = (i == nv - 1);
            end
            send_vertex(qx, qy, rnd_coord(mode), rnd_coord(mode), fst, lst);
            if (!calm)
                idle_item(gap_len());
        end
    endtask

    task automatic square(coord_t qx, coord_t qy, coord_t r);
        send_vertex(qx, qy, -r, -r, 1'b1, 1'b0);
        send_vertex(qx, qy,  r, -r, 1'b0, 1'b0);
        send_vertex(qx, qy,  r,  r, 1'b0, 1'b0);
        send_vertex(qx, qy, -r,  r, 1'b0, 1'b1);
    endtask

    // Result side: random stalls of mostly short length.
    initial
    begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            res_ch.ready = 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge clk);
            n = gap_len();
            if (n > 0)
            begin
                @(negedge clk);
                res_ch.ready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_inside(res_ch.inside_res);
    end

    initial
    begin
        coord_t far_list[7];
        rst_n                = 1'b0;
        sent                 = 0;
        item_ch.valid        = 1'b0;
        item_ch.query_x      = '0;
        item_ch.query_y      = '0;
        item_ch.vertex_x     = '0;
        item_ch.vertex_y     = '0;
        item_ch.first_vertex = 1'b0;
        item_ch.last_vertex  = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.ray_far_x     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Middle vertex straight after reset, continuing from the cleared state.
        send_vertex(16'sd0, 16'sd0, 16'sd5, 16'sd5, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd0, 16'sd5, -16'sd5, 1'b0, 1'b1);
        // Single-vertex polygons, on and behind the ray.
        send_vertex(16'sd0, 16'sd0, 16'sd3, 16'sd0, 1'b1, 1'b1);
        send_vertex(16'sd0, 16'sd0, -16'sd3, 16'sd0, 1'b1, 1'b1);
        square(16'sd0, 16'sd0, 16'sd10);
        // Keep going after the last vertex without a new first.
        send_vertex(16'sd0, 16'sd0, 16'sd20, 16'sd20, 1'b0, 1'b1);
        send_vertex(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1, 1'b0);
        send_vertex(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0, 1'b0);
        send_vertex(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 1'b1);
        send_vertex(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 1'b1, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0, 1'b1);

        // Leftward ray from the query point.
        write_far(-16'sd32768);
        square(16'sd0, 16'sd0, 16'sd10);
        send_vertex(16'sd0, 16'sd0, -16'sd5, 16'sd0, 1'b1, 1'b0);
        send_vertex(16'sd0, 16'sd0, -16'sd5, 16'sd4, 1'b0, 1'b1);
        write_far(16'sd32767);
        send_vertex(16'sd32767, 16'sd0, 16'sd32767, 16'sd0, 1'b1, 1'b1);

        far_list[0] = 16'sd32767;
        far_list[1] = 16'sd0;
        far_list[2] = rnd_coord(1);
        far_list[3] = -16'sd32768;
        far_list[4] = coord_t'(pip_pkg::RAY_FAR_RESET);
        far_list[5] = rnd_coord(0);
        far_list[6] = rnd_coord(2);
        for (int p = 0; p < 7; p++)
        begin
            write_far(far_list[p]);
            while (sent < 20 + (p + 1) * 80)
                random_polygon();
        end

        idle_item(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
